### src/multiset_combination_generator_assert.svh
// Assertion macros for the multiset combination generator.
// Both expect signals named clock and reset in the scope of use.
`ifndef MULTISET_COMBINATION_GENERATOR_ASSERT_SVH
`define MULTISET_COMBINATION_GENERATOR_ASSERT_SVH

// Check a consequence in the same cycle as its trigger.
`define MCG_ASSERT_NOW(label, trig, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (expr)) \
      else $error(msg);

// Check a consequence in the cycle after its trigger.
`define MCG_ASSERT_NEXT(label, trig, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (expr)) \
      else $error(msg);

`endif

### src/mcg_pkg.sv
package mcg_pkg;

   localparam int NPOS           = 8;
   localparam int POS_W          = $clog2(NPOS);
   localparam int LEN_W          = 4;
   localparam int ELEM_W         = 16;
   localparam int VALUE_IN_W     = 16;
   localparam int ACTION_W       = 2;
   localparam int MAX_VALUES_DEF = 8;
   localparam int VALUE_BITS_DEF = 16;

   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_NEXT  = 2'd2;

   typedef struct packed {
      logic clear;
      logic load;
      logic adv;
      logic read;
      logic send;
   } mcg_cmd_type;

   typedef struct packed {
      logic out_free;
      logic rd_last;
   } mcg_status_type;

endpackage

### src/mcg_channels.sv
interface mcg_req_if import mcg_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [ACTION_W-1:0]   action;
   logic [VALUE_IN_W-1:0] value;

   modport source (output valid, action, value, input ready);
   modport sink   (input valid, action, value, output ready);
endinterface

interface mcg_rsp_if import mcg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ELEM_W-1:0] elem_0;
   logic [ELEM_W-1:0] elem_1;
   logic [ELEM_W-1:0] elem_2;
   logic [ELEM_W-1:0] elem_3;
   logic [ELEM_W-1:0] elem_4;
   logic [ELEM_W-1:0] elem_5;
   logic [ELEM_W-1:0] elem_6;
   logic [ELEM_W-1:0] elem_7;
   logic              seq_valid;
   logic              is_final;

   modport source (output valid, elem_0, elem_1, elem_2, elem_3, elem_4, elem_5, elem_6,
                   elem_7, seq_valid, is_final, input ready);
   modport sink   (input valid, elem_0, elem_1, elem_2, elem_3, elem_4, elem_5, elem_6,
                   elem_7, seq_valid, is_final, output ready);
endinterface

interface mcg_csr_if import mcg_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] seq_length;

   modport source (output valid, seq_length, input ready);
   modport sink   (input valid, seq_length, output ready);
endinterface

### src/multiset_combination_generator.sv
// Multiset combination generator.
// req_chan carries an action and a value: clear empties the value store, load
// inserts a value into the sorted store of distinct values (duplicates and loads
// into a full store are dropped), next asks for the following non-decreasing
// sequence of seq_length elements (clamped to 1..NPOS). Clear, load and
// unknown actions give no item on rsp_chan; next gives exactly one item with
// elem_0..elem_7, seq_valid and is_final. csr_chan writes seq_length (always
// ready) and restarts the sequence order; write it only while the block is idle.
// Clear and load take effect at the accepting edge. For a next, the position
// indices advance at the accepting edge, the read state fetches the elements
// one per cycle through the single value select path, and the send state hands
// the item to the output register. req_chan is not ready while a next is in
// progress, so a new next waits until the last item reaches the output register.
// The output register holds a finished item while rsp_chan stalls; the block
// keeps taking clear and load items meanwhile, and a further next waits at its
// handoff until the held item is taken.
// Reset empties the store, sets seq_length to 1 and restarts the order; there
// is no clearing pass, the block is ready in the first cycle after reset.
`include "multiset_combination_generator_assert.svh"

module multiset_combination_generator import mcg_pkg::*; #(
   parameter int MAX_VALUES = MAX_VALUES_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   mcg_req_if.sink   req_chan,
   mcg_rsp_if.source rsp_chan,
   mcg_csr_if.sink   csr_chan
);

   mcg_cmd_type    cmd;
   mcg_status_type status;
   logic           csr_we;
   logic [ELEM_W-1:0] rsp_elem [NPOS];

   assign csr_chan.ready = 1'b1;
   assign csr_we         = csr_chan.valid && csr_chan.ready;

   mcg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .req_ready  (req_chan.ready),
      .cmd        (cmd),
      .status     (status)
   );

   mcg_dpath #(
      .MAX_VALUES (MAX_VALUES),
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_value     (req_chan.value),
      .csr_we        (csr_we),
      .csr_data      (csr_chan.seq_length),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_elem      (rsp_elem),
      .rsp_seq_valid (rsp_chan.seq_valid),
      .rsp_is_final  (rsp_chan.is_final)
   );

   assign rsp_chan.elem_0 = rsp_elem[0];
   assign rsp_chan.elem_1 = rsp_elem[1];
   assign rsp_chan.elem_2 = rsp_elem[2];
   assign rsp_chan.elem_3 = rsp_elem[3];
   assign rsp_chan.elem_4 = rsp_elem[4];
   assign rsp_chan.elem_5 = rsp_elem[5];
   assign rsp_chan.elem_6 = rsp_elem[6];
   assign rsp_chan.elem_7 = rsp_elem[7];

   `MCG_ASSERT_NOW(a_send_free, cmd.send, status.out_free, "held item overwritten")
   `MCG_ASSERT_NEXT(a_next_busy, req_chan.valid && req_chan.ready && req_chan.action == ACT_NEXT, !req_chan.ready, "ready during next")
   `MCG_ASSERT_NEXT(a_send_shows, cmd.send, rsp_chan.valid, "handoff lost")
   `MCG_ASSERT_NOW(a_empty_item, rsp_chan.valid && !rsp_chan.seq_valid, !rsp_chan.is_final && rsp_chan.elem_0 == '0, "bad empty item")

endmodule

### src/mcg_ctrl.sv
module mcg_ctrl import mcg_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [ACTION_W-1:0] req_action,
   output logic                req_ready,
   output mcg_cmd_type         cmd,
   input  mcg_status_type      status
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_SEND
   } state_type;

   state_type state_ff;
   logic      accept;

   always_comb begin
      req_ready  = (state_ff == S_IDLE);
      accept     = req_valid && req_ready;
      cmd.clear  = accept && (req_action == ACT_CLEAR);
      cmd.load   = accept && (req_action == ACT_LOAD);
      cmd.adv    = accept && (req_action == ACT_NEXT);
      cmd.read   = (state_ff == S_READ);
      cmd.send   = (state_ff == S_SEND) && status.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (cmd.adv) state_ff <= S_READ;
            end
            S_READ: begin
               if (status.rd_last) state_ff <= S_SEND;
            end
            S_SEND: begin
               // hold until the output register can take the item
               if (status.out_free) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

### src/mcg_dpath.sv
module mcg_dpath import mcg_pkg::*; #(
   parameter int MAX_VALUES = MAX_VALUES_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mcg_cmd_type           cmd,
   output mcg_status_type        status,
   input  logic [VALUE_IN_W-1:0] req_value,
   input  logic                  csr_we,
   input  logic [LEN_W-1:0]      csr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [ELEM_W-1:0]     rsp_elem [NPOS],
   output logic                  rsp_seq_valid,
   output logic                  rsp_is_final
);

   localparam int CNT_W = $clog2(MAX_VALUES + 1);
   localparam int IDX_W = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;

   // value store, sorted ascending, entries at and above count_ff unused
   logic [VALUE_BITS-1:0] val_ff [MAX_VALUES];
   logic [VALUE_BITS-1:0] val_in [MAX_VALUES];
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      idx_ff [NPOS];
   logic [IDX_W-1:0]      idx_in [NPOS];
   logic                  started_ff, started_in;
   logic                  exhausted_ff, exhausted_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [POS_W-1:0]      rd_cnt_ff, rd_cnt_in;
   logic                  prod_ff, prod_in;
   logic                  final_ff, final_in;
   logic [ELEM_W-1:0]     stage_ff [NPOS];
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ELEM_W-1:0]     out_elem_ff [NPOS];
   logic                  out_seq_ff, out_final_ff;

   logic [LEN_W-1:0]      eff_len;
   logic [VALUE_BITS+VALUE_IN_W-1:0] v_wide;
   logic [VALUE_BITS-1:0] v_new;
   logic [MAX_VALUES-1:0] lt, eq, first;
   logic [VALUE_BITS-1:0] prev_val [MAX_VALUES];
   logic [VALUE_BITS-1:0] ins_val [MAX_VALUES];
   logic                  ins_ok;
   logic [CNT_W-1:0]      top_w;
   logic [NPOS-1:0]       grow;
   logic                  found;
   logic [POS_W-1:0]      p_sel;
   logic [IDX_W-1:0]      inc_val;
   logic [IDX_W-1:0]      adv_idx [NPOS];
   logic [IDX_W-1:0]      new_idx0;
   logic [VALUE_BITS+ELEM_W-1:0] rd_wide;
   logic [ELEM_W-1:0]     rd_elem;

   // insertion: parallel compares over the live cells, then shift right of the slot
   always_comb begin
      v_wide = {{VALUE_BITS{1'b0}}, req_value};
      v_new  = v_wide[VALUE_BITS-1:0];
      for (int i = 0; i < MAX_VALUES; i++) begin
         lt[i] = (CNT_W'(i) < count_ff) && (val_ff[i] < v_new);
         eq[i] = (CNT_W'(i) < count_ff) && (val_ff[i] == v_new);
      end
      first[0]    = 1'b1;
      prev_val[0] = v_new;
      for (int i = 1; i < MAX_VALUES; i++) begin
         first[i]    = lt[i-1];
         prev_val[i] = val_ff[i-1];
      end
      for (int i = 0; i < MAX_VALUES; i++) begin
         if (lt[i]) ins_val[i] = val_ff[i];
         else if (first[i]) ins_val[i] = v_new;
         else ins_val[i] = prev_val[i];
      end
      ins_ok = !(|eq) && (count_ff < CNT_W'(MAX_VALUES));
   end

   // advance: rightmost growable position, bump it, copy rightward
   always_comb begin
      if (len_ff == '0) eff_len = LEN_W'(1);
      else if (len_ff > LEN_W'(NPOS)) eff_len = LEN_W'(NPOS);
      else eff_len = len_ff;
      top_w = count_ff - CNT_W'(1);
      found = 1'b0;
      p_sel = '0;
      for (int q = 0; q < NPOS; q++) begin
         grow[q] = (LEN_W'(q) < eff_len) && (CNT_W'(idx_ff[q]) < top_w);
         if (grow[q]) begin
            found = 1'b1;
            p_sel = POS_W'(q);
         end
      end
      inc_val = idx_ff[p_sel] + IDX_W'(1);
      for (int q = 0; q < NPOS; q++) begin
         if ((POS_W'(q) >= p_sel) && (LEN_W'(q) < eff_len)) adv_idx[q] = inc_val;
         else adv_idx[q] = idx_ff[q];
      end
      new_idx0 = started_ff ? adv_idx[0] : '0;
   end

   always_comb begin
      rd_wide = {{ELEM_W{1'b0}}, val_ff[idx_ff[rd_cnt_ff]]};
      if (prod_ff && (LEN_W'(rd_cnt_ff) < eff_len)) rd_elem = rd_wide[ELEM_W-1:0];
      else rd_elem = '0;
   end

   always_comb begin
      val_in       = val_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      started_in   = started_ff;
      exhausted_in = exhausted_ff;
      len_in       = len_ff;
      rd_cnt_in    = rd_cnt_ff;
      prod_in      = prod_ff;
      final_in     = final_ff;
      priority if (csr_we) begin
         len_in       = csr_data;
         idx_in       = '{default: '0};
         started_in   = 1'b0;
         exhausted_in = 1'b0;
      end else if (cmd.clear) begin
         count_in     = '0;
         idx_in       = '{default: '0};
         started_in   = 1'b0;
         exhausted_in = 1'b0;
      end else if (cmd.load) begin
         if (ins_ok) begin
            val_in       = ins_val;
            count_in     = count_ff + CNT_W'(1);
            idx_in       = '{default: '0};
            started_in   = 1'b0;
            exhausted_in = 1'b0;
         end
      end else if (cmd.adv) begin
         rd_cnt_in = '0;
         prod_in   = 1'b0;
         final_in  = 1'b0;
         if ((count_ff != '0) && !exhausted_ff) begin
            if (!started_ff || found) begin
               prod_in      = 1'b1;
               started_in   = 1'b1;
               if (started_ff) idx_in = adv_idx;
               else idx_in = '{default: '0};
               final_in     = (CNT_W'(new_idx0) >= top_w);
               exhausted_in = (CNT_W'(new_idx0) >= top_w);
            end else begin
               exhausted_in = 1'b1;
            end
         end
      end else if (cmd.read) begin
         rd_cnt_in = rd_cnt_ff + POS_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.send) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '{default: '0};
         started_ff   <= 1'b0;
         exhausted_ff <= 1'b0;
         len_ff       <= LEN_RESET;
         rd_cnt_ff    <= '0;
         prod_ff      <= 1'b0;
         final_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         started_ff   <= started_in;
         exhausted_ff <= exhausted_in;
         len_ff       <= len_in;
         rd_cnt_ff    <= rd_cnt_in;
         prod_ff      <= prod_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      if (cmd.read) stage_ff[rd_cnt_ff] <= rd_elem;
      if (cmd.send) begin
         out_elem_ff  <= stage_ff;
         out_seq_ff   <= prod_ff;
         out_final_ff <= final_ff;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.rd_last  = (rd_cnt_ff == POS_W'(NPOS - 1));
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_elem        = out_elem_ff;
   assign rsp_seq_valid   = out_seq_ff;
   assign rsp_is_final    = out_final_ff;

endmodule

### sim/multiset_combination_generator_tb.sv
`timescale 1ns / 1ps

module multiset_combination_generator_tb;
   import mcg_pkg::*;

   localparam int DRAIN_CYCLES    = 12;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int IDLE_LIMIT      = 5000;
   localparam int ITEM_TARGET     = 1550;
   localparam int STORE_DEPTH     = MAX_VALUES_DEF;
   localparam int DIRECTED_ROWS   = 22;

   // Unused action code, the block drops it.
   localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

   typedef struct packed {
      logic [NPOS-1:0][ELEM_W-1:0] elems;
      logic                        seq_valid;
      logic                        is_final;
   } seq_result_type;

   typedef struct packed {
      logic [ACTION_W-1:0]   act;
      logic [VALUE_IN_W-1:0] val;
      logic                  typed;
      logic [ELEM_W-1:0]     first;
      logic                  seq_valid;
      logic                  is_final;
   } step_row_type;

   logic clock;
   logic reset;

   mcg_req_if req_bus ();
   mcg_rsp_if rsp_bus ();
   mcg_csr_if csr_bus ();

   multiset_combination_generator u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Shadow state of the generator.
   logic [ELEM_W-1:0] shadow_vals [STORE_DEPTH];
   int unsigned       shadow_count;
   logic [POS_W-1:0]  walk_idx [NPOS];
   bit                walk_started;
   bit                walk_done;
   logic [LEN_W-1:0]  length_reg;

   seq_result_type expected_seqs [$];
   int unsigned error_count;
   int unsigned items_sent;
   int unsigned idle_cycles;
   bit          quiet_mode;
   bit          hold_off_pending;

   // Length 1 at reset, so every typed row only has elem_0 set.
   step_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ACT_NEXT,  16'h0000, 1'b1, 16'h0000, 1'b0, 1'b0},   // empty store
      '{ACT_NONE,  16'hffff, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{ACT_LOAD,  16'hffff, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{ACT_LOAD,  16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{ACT_LOAD,  16'hffff, 1'b0, 16'h0000, 1'b0, 1'b0},   // duplicate
      '{ACT_NEXT,  16'h0000, 1'b1, 16'h0000, 1'b1, 1'b0},
      '{ACT_NEXT,  16'hffff, 1'b1, 16'hffff, 1'b1, 1'b1},
      '{ACT_NEXT,  16'h0000, 1'b1, 16'h0000, 1'b0, 1'b0},   // past the last one
      '{ACT_NEXT,  16'h8000, 1'b1, 16'h0000, 1'b0, 1'b0},
      '{ACT_CLEAR, 16'h5a5a, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{ACT_NEXT,  16'h0000, 1'b1, 16'h0000, 1'b0, 1'b0},
      '{ACT_LOAD,  16'h0005, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{ACT_LOAD,  16'h0003, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{ACT_LOAD,  16'h0009, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{ACT_LOAD,  16'h0001, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{ACT_LOAD,  16'h0007, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{ACT_LOAD,  16'h8000, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{ACT_LOAD,  16'h0002, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{ACT_LOAD,  16'haaaa, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{ACT_LOAD,  16'h1234, 1'b0, 16'h0000, 1'b0, 1'b0},   // store full
      '{ACT_NEXT,  16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{ACT_NEXT,  16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void restart_walk();
      for (int i = 0; i < NPOS; i++) walk_idx[i] = '0;
      walk_started = 1'b0;
      walk_done    = 1'b0;
   endfunction

   function automatic void insert_value(input logic [ELEM_W-1:0] v);
      int unsigned slot;
      slot = 0;
      while (slot < shadow_count && shadow_vals[slot] < v) slot++;
      if (slot < shadow_count && shadow_vals[slot] == v) return;
      if (shadow_count >= STORE_DEPTH) return;
      for (int i = shadow_count; i > slot; i--) shadow_vals[i] = shadow_vals[i-1];
      shadow_vals[slot] = v;
      shadow_count++;
      restart_walk();
   endfunction

   // Apply one item to the shadow state; return 1 when it yields a sequence item.
   function automatic bit next_sequence(input logic [ACTION_W-1:0] act,
                                        input logic [VALUE_IN_W-1:0] val,
                                        output seq_result_type res);
      int unsigned len, top, p;
      bit          produced;
      res      = '0;
      produced = 1'b0;
      case (act)
         ACT_CLEAR: begin
            shadow_count = 0;
            restart_walk();
            return 1'b0;
         end
         ACT_LOAD: begin
            insert_value(val);
            return 1'b0;
         end
         ACT_NEXT: ;
         default: return 1'b0;
      endcase
      if (length_reg < 1) len = 1;
      else if (length_reg > NPOS) len = NPOS;
      else len = length_reg;
      if (shadow_count == 0 || walk_done) return 1'b1;
      top = shadow_count - 1;
      if (!walk_started) begin
         for (int i = 0; i < NPOS; i++) walk_idx[i] = '0;
         walk_started = 1'b1;
         produced     = 1'b1;
      end else begin
         // find the rightmost position that can still grow
         p = len;
         while (p > 0 && walk_idx[p-1] >= top) p--;
         if (p > 0) begin
            p--;
            walk_idx[p]++;
            for (int q = p + 1; q < len; q++) walk_idx[q] = walk_idx[p];
            produced = 1'b1;
         end else begin
            walk_done = 1'b1;
         end
      end
      if (!produced) return 1'b1;
      for (int i = 0; i < len; i++) res.elems[i] = shadow_vals[walk_idx[i]];
      res.seq_valid = 1'b1;
      res.is_final  = (walk_idx[0] >= top);
      if (res.is_final) walk_done = 1'b1;
      return 1'b1;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (quiet_mode) return 0;
      r = $urandom_range(0, 19);
      if (r < 12) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [VALUE_IN_W-1:0] rand_value(input bit narrow);
      int unsigned r;
      if (narrow) return VALUE_IN_W'($urandom_range(0, 15));
      r = $urandom_range(0, 15);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return VALUE_IN_W'($urandom);
   endfunction

   task automatic send_item(input logic [ACTION_W-1:0] act, input logic [VALUE_IN_W-1:0] val,
                            input bit typed, input seq_result_type want);
      seq_result_type predicted;
      int unsigned    gap;
      req_bus.valid  <= 1'b1;
      req_bus.action <= act;
      req_bus.value  <= val;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (next_sequence(act, val, predicted)) expected_seqs.push_back(typed ? want : predicted);
      if (act != ACT_NONE) items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_length(input logic [LEN_W-1:0] len);
      csr_bus.valid      <= 1'b1;
      csr_bus.seq_length <= len;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      length_reg = len;
      restart_walk();
      csr_bus.valid <= 1'b0;
   endtask

   // Hold the input until every sequence item is back and the pipe is empty.
   task automatic drain();
      if (req_bus.valid === 1'b1) req_bus.valid <= 1'b0;
      while (expected_seqs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Result checker.
   always @(posedge clock) begin
      seq_result_type              want;
      logic [NPOS-1:0][ELEM_W-1:0] got;
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_seqs.size() == 0) begin
            $error("unexpected sequence item on rsp_chan");
            error_count++;
         end else begin
            want = expected_seqs.pop_front();
            got  = {rsp_bus.elem_7, rsp_bus.elem_6, rsp_bus.elem_5, rsp_bus.elem_4,
                    rsp_bus.elem_3, rsp_bus.elem_2, rsp_bus.elem_1, rsp_bus.elem_0};
            for (int k = 0; k < NPOS; k++) begin
               if (got[k] !== want.elems[k]) begin
                  $error("elem_%0d: expected %h, got %h", k, want.elems[k], got[k]);
                  error_count++;
               end
            end
            if (rsp_bus.seq_valid !== want.seq_valid) begin
               $error("seq_valid: expected %b, got %b", want.seq_valid, rsp_bus.seq_valid);
               error_count++;
            end
            if (rsp_bus.is_final !== want.is_final) begin
               $error("is_final: expected %b, got %b", want.is_final, rsp_bus.is_final);
               error_count++;
            end
         end
      end
   end

   // Watchdog: no item moving on any channel for too long.
   always @(posedge clock) begin
      if (reset !== 1'b0) begin
         idle_cycles <= 0;
      end else if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
                   (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
                   (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("multiset_combination_generator test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      int unsigned r;
      rsp_bus.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         r = $urandom_range(0, 19);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (quiet_mode || r < 14) begin
            rsp_bus.ready <= 1'b1;
            repeat (quiet_mode ? 1 : $urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b0;
            repeat (r < 19 ? $urandom_range(1, 4) : $urandom_range(15, 50)) @(posedge clock);
         end
      end
   end

   initial begin
      int unsigned      phase;
      int unsigned      n_loads;
      int unsigned      n_next;
      logic [LEN_W-1:0] len;
      bit               narrow;
      seq_result_type   want;
      error_count      = 0;
      items_sent       = 0;
      quiet_mode       = 1'b0;
      hold_off_pending = 1'b0;
      shadow_count     = 0;
      length_reg       = LEN_RESET;
      restart_walk();
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.action     <= ACT_CLEAR;
      req_bus.value      <= '0;
      csr_bus.valid      <= 1'b0;
      csr_bus.seq_length <= LEN_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         want           = '0;
         want.elems[0]  = directed_rows[i].first;
         want.seq_valid = directed_rows[i].seq_valid;
         want.is_final  = directed_rows[i].is_final;
         send_item(directed_rows[i].act, directed_rows[i].val, directed_rows[i].typed, want);
      end

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         drain();
         case (phase)
            0:       len = LEN_W'(NPOS);
            1:       len = '0;
            2:       len = '1;
            3:       len = LEN_W'(1);
            default: len = LEN_W'($urandom_range(0, 15));
         endcase
         write_length(len);
         quiet_mode = (phase % 5 == 4);

         if (phase == 2 || phase == 9) begin
            // stall the output for a long stretch while nexts keep coming
            quiet_mode       = 1'b1;
            hold_off_pending = 1'b1;
            send_item(ACT_CLEAR, rand_value(1'b0), 1'b0, '0);
            repeat (3) send_item(ACT_LOAD, rand_value(1'b0), 1'b0, '0);
            repeat (20) send_item(ACT_NEXT, rand_value(1'b0), 1'b0, '0);
            quiet_mode = 1'b0;
         end

         repeat (4) begin
            if ($urandom_range(0, 9) < 7) begin
               narrow = ($urandom_range(0, 3) == 0);
               send_item(ACT_CLEAR, rand_value(1'b0), 1'b0, '0);
               n_loads = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 11)
                                                     : $urandom_range(1, 4);
               repeat (n_loads) send_item(ACT_LOAD, rand_value(narrow), 1'b0, '0);
               n_next = $urandom_range(1, 40);
               repeat (n_next) begin
                  // a load that inserts a new value in the middle of a walk restarts it
                  if ($urandom_range(0, 29) == 0)
                     send_item(ACT_LOAD, rand_value(narrow), 1'b0, '0);
                  send_item(ACT_NEXT, rand_value(1'b0), 1'b0, '0);
               end
            end else begin
               repeat ($urandom_range(1, 8))
                  send_item(ACTION_W'($urandom_range(0, 3)), rand_value(1'b0), 1'b0, '0);
            end
         end
         phase++;
      end

      drain();
      if (error_count == 0)
         $display("multiset_combination_generator test passed");
      else
         $display("multiset_combination_generator test failed");
      $finish;
   end

endmodule

### multiset_combination_generator.f
+incdir+src
src/mcg_pkg.sv
src/mcg_channels.sv
src/mcg_ctrl.sv
src/mcg_dpath.sv
src/multiset_combination_generator.sv
sim/multiset_combination_generator_tb.sv
